### src/hrte_pkg.sv
package hrte_pkg;

  // character codes
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // pattern wildcards: tag name terminator and heading digit
  localparam logic [7:0] PAT_TERM  = 8'h23;
  localparam logic [7:0] PAT_DIGIT = 8'h25;

  localparam int NUM_OPEN = 8;

  // opening pattern slots that switch into a body mode, the rest are block closes
  localparam logic [2:0] PAT_COMMENT = 3'd0;
  localparam logic [2:0] PAT_SCRIPT  = 3'd1;
  localparam logic [2:0] PAT_STYLE   = 3'd2;

  // opening patterns after '<', first character in the highest used byte
  localparam logic [6:0][7:0] OPEN_PAT [NUM_OPEN] = '{
    "!--", "script#", "style#", "/p>", "/div>", "/li>", "/br>", "/h%>"
  };
  localparam logic [2:0] OPEN_LEN [NUM_OPEN] = '{
    3'd3, 3'd7, 3'd6, 3'd3, 3'd5, 3'd4, 3'd4, 3'd4
  };

  // closing tag tails after '<'
  localparam logic [7:0][7:0] SCRIPT_TAIL = "/script>";
  localparam logic [6:0][7:0] STYLE_TAIL  = "/style>";
  localparam logic [3:0] SCRIPT_CLOSE_LEN = 4'd9;
  localparam logic [3:0] STYLE_CLOSE_LEN  = 4'd8;

  function automatic logic [7:0] fold(input logic [7:0] b);
    return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_NL || b == CH_CR;
  endfunction

  function automatic logic pat_ok(input logic [7:0] p, input logic [7:0] b);
    if (p == PAT_TERM) begin
      return b == CH_GT || is_ws(b);
    end else if (p == PAT_DIGIT) begin
      return b >= CH_1 && b <= CH_6;
    end
    return fold(b) == p;
  endfunction

  // character idx (from 0) of opening pattern k
  function automatic logic [7:0] open_char(input logic [2:0] k, input logic [2:0] idx);
    logic [2:0] sel;
    sel = OPEN_LEN[k] - 3'd1 - idx;
    return OPEN_PAT[k][sel];
  endfunction

  function automatic logic [7:0] script_char(input logic [2:0] idx);
    return SCRIPT_TAIL[~idx];
  endfunction

  function automatic logic [7:0] style_char(input logic [2:0] idx);
    logic [2:0] sel;
    sel = 3'd6 - idx;
    return STYLE_TAIL[sel];
  endfunction

endpackage

### src/html_readable_text_extractor_top.sv
// html readable text extractor: takes an html document one byte per request on the s_ side
// (s_tlast on the final byte) and returns its readable text on the m_ side. tags, comments and
// script and style bodies are dropped, whitespace runs collapse to a single space, and closing
// p, div, li, br and h1..h6 tags make the pending separator a newline once text has been seen.
// a separator goes out only right before the next text byte, so a trailing one is dropped. every
// input byte is handled in the cycle it is accepted, one byte per cycle while s_tready is high;
// its results land in a four-entry result queue and show up on the m_ side from the next cycle.
// a byte can yield two results (separator plus text byte), and the queue drains one result per
// cycle while m_tready is high, so s_tready drops whenever fewer than two queue slots are free.
// the document's end request always yields at least one result (an end marker with tuser 0 when
// it carries no text) with m_tlast set, and clears all parser state.
module html_readable_text_extractor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // doc_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
  output logic        m_tuser,   // byte_valid
  output logic        m_tlast    // doc_end
);

  typedef enum logic [2:0] {
    MODE_TEXT    = 3'd0,
    MODE_TAG     = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_SCRIPT  = 3'd3,
    MODE_STYLE   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    SEP_NONE    = 2'd0,
    SEP_SPACE   = 2'd1,
    SEP_NEWLINE = 2'd2
  } sep_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       doc_end;
  } res_t;

  // parser state
  mode_t      mode, mode_next;
  logic [3:0] open_pos, open_pos_next;
  logic [7:0] open_cand, open_cand_next;
  logic [3:0] close_pos, close_pos_next;
  sep_t       pend, pend_next;
  logic       started, started_next;

  // results of the byte being accepted
  res_t       res0, res1;
  logic [1:0] res_cnt;

  // result queue
  res_t       fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  logic       in_acc, out_acc;
  logic [7:0] b;
  logic       close_hit;
  logic       done_found;
  logic [2:0] done_k;
  logic [2:0] open_idx, close_idx;

  assign b       = s_tdata;
  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // room for the worst case of two results
  assign s_tready = count <= 3'd2;

  assign open_idx  = open_pos[2:0] - 3'd1;
  assign close_idx = close_pos[2:0] - 3'd1;

  always_comb begin
    mode_next      = mode;
    open_pos_next  = open_pos;
    open_cand_next = open_cand;
    close_pos_next = close_pos;
    pend_next      = pend;
    started_next   = started;
    res0           = '0;
    res1           = '0;
    res_cnt        = 2'd0;
    done_found     = 1'b0;
    done_k         = 3'd0;
    close_hit      = 1'b0;

    unique case (mode)
      MODE_TAG: begin
        if (b == hrte_pkg::CH_LT) begin
          // a new '<' restarts the opening matchers, tag goes on
          open_pos_next  = 4'd1;
          open_cand_next = '1;
        end else begin
          if (open_cand != 8'd0 && open_pos >= 4'd1 && open_pos <= 4'd7) begin
            for (int k = 0; k < hrte_pkg::NUM_OPEN; k++) begin
              if (open_cand[k]) begin
                if (open_pos <= {1'b0, hrte_pkg::OPEN_LEN[k]} &&
                    hrte_pkg::pat_ok(hrte_pkg::open_char(3'(k), open_idx), b)) begin
                  if (open_pos == {1'b0, hrte_pkg::OPEN_LEN[k]} && !done_found) begin
                    done_found = 1'b1;
                    done_k     = 3'(k);
                  end
                end else begin
                  open_cand_next[k] = 1'b0;
                end
              end
            end
            open_pos_next = open_pos + 4'd1;
          end else begin
            open_cand_next = '0;
          end
          if (done_found) begin
            open_cand_next = '0;
            open_pos_next  = '0;
            close_pos_next = '0;
            priority case (done_k)
              hrte_pkg::PAT_COMMENT: mode_next = MODE_COMMENT;
              hrte_pkg::PAT_SCRIPT:  mode_next = MODE_SCRIPT;
              hrte_pkg::PAT_STYLE:   mode_next = MODE_STYLE;
              default: begin
                // block-level close tag
                if (started) pend_next = SEP_NEWLINE;
                mode_next = MODE_TEXT;
              end
            endcase
          end else if (b == hrte_pkg::CH_GT) begin
            mode_next      = MODE_TEXT;
            open_cand_next = '0;
            open_pos_next  = '0;
          end
        end
      end

      MODE_COMMENT: begin
        if (b == hrte_pkg::CH_DASH) begin
          close_pos_next = (close_pos < 4'd2) ? close_pos + 4'd1 : 4'd2;
        end else if (b == hrte_pkg::CH_GT && close_pos == 4'd2) begin
          mode_next      = MODE_TEXT;
          close_pos_next = '0;
        end else begin
          close_pos_next = '0;
        end
      end

      MODE_SCRIPT, MODE_STYLE: begin
        if (mode == MODE_SCRIPT) begin
          close_hit = close_pos >= 4'd1 && close_pos < hrte_pkg::SCRIPT_CLOSE_LEN &&
                      hrte_pkg::fold(b) == hrte_pkg::script_char(close_idx);
        end else begin
          close_hit = close_pos >= 4'd1 && close_pos < hrte_pkg::STYLE_CLOSE_LEN &&
                      hrte_pkg::fold(b) == hrte_pkg::style_char(close_idx);
        end
        if (b == hrte_pkg::CH_LT) begin
          close_pos_next = 4'd1;
        end else if (close_hit) begin
          close_pos_next = close_pos + 4'd1;
          if ((mode == MODE_SCRIPT && close_pos_next == hrte_pkg::SCRIPT_CLOSE_LEN) ||
              (mode == MODE_STYLE && close_pos_next == hrte_pkg::STYLE_CLOSE_LEN)) begin
            mode_next      = MODE_TEXT;
            close_pos_next = '0;
          end
        end else begin
          close_pos_next = '0;
        end
      end

      default: begin
        // text mode, unused codes fall back here too
        mode_next = MODE_TEXT;
        if (b == hrte_pkg::CH_LT) begin
          mode_next      = MODE_TAG;
          open_pos_next  = 4'd1;
          open_cand_next = '1;
        end else if (hrte_pkg::is_ws(b)) begin
          if (started && pend == SEP_NONE) pend_next = SEP_SPACE;
        end else begin
          if (pend != SEP_NONE) begin
            res0.out_byte   = (pend == SEP_SPACE) ? hrte_pkg::CH_SPACE : hrte_pkg::CH_NL;
            res0.byte_valid = 1'b1;
            res1.out_byte   = b;
            res1.byte_valid = 1'b1;
            res1.run_last   = 1'b1;
            res_cnt         = 2'd2;
          end else begin
            res0.out_byte   = b;
            res0.byte_valid = 1'b1;
            res0.run_last   = 1'b1;
            res_cnt         = 2'd1;
          end
          pend_next    = SEP_NONE;
          started_next = 1'b1;
        end
      end
    endcase

    if (s_tlast) begin
      // document end: mark the last result, or send a bare end marker
      priority case (res_cnt)
        2'd2: res1.doc_end = 1'b1;
        2'd1: res0.doc_end = 1'b1;
        default: begin
          res0.run_last = 1'b1;
          res0.doc_end  = 1'b1;
          res_cnt       = 2'd1;
        end
      endcase
      mode_next      = MODE_TEXT;
      open_pos_next  = '0;
      open_cand_next = '0;
      close_pos_next = '0;
      pend_next      = SEP_NONE;
      started_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_TEXT;
      open_pos  <= '0;
      open_cand <= '0;
      close_pos <= '0;
      pend      <= SEP_NONE;
      started   <= 1'b0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
    end else begin
      if (in_acc) begin
        mode      <= mode_next;
        open_pos  <= open_pos_next;
        open_cand <= open_cand_next;
        close_pos <= close_pos_next;
        pend      <= pend_next;
        started   <= started_next;
        wr_ptr    <= wr_ptr + res_cnt;
      end
      if (out_acc) rd_ptr <= rd_ptr + 2'd1;
      count <= count + (in_acc ? {1'b0, res_cnt} : 3'd0) - {2'b0, out_acc};
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (res_cnt != 2'd0) fifo[wr_ptr] <= res0;
      if (res_cnt == 2'd2) fifo[wr_ptr + 2'd1] <= res1;
    end
  end

  assign m_tvalid = count != 3'd0;
  assign m_tdata  = {7'd0, fifo[rd_ptr].run_last, fifo[rd_ptr].out_byte};
  assign m_tuser  = fifo[rd_ptr].byte_valid;
  assign m_tlast  = fifo[rd_ptr].doc_end;

`ifndef SYNTHESIS
  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue overflow");

  // the opening matcher position never runs past one beyond the longest pattern
  a_open_pos: assert property (@(posedge clk) disable iff (rst) open_pos <= 4'd8)
    else $error("opening matcher position out of range");

  // no separator can be pending before any text
  a_sep_started: assert property (@(posedge clk) disable iff (rst)
    !started |-> pend == SEP_NONE)
    else $error("separator pending before text");

  // document end clears the parser
  a_doc_reset: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tlast |=> mode == MODE_TEXT && pend == SEP_NONE && !started &&
                          open_cand == 8'd0 && close_pos == 4'd0)
    else $error("state not cleared at document end");

  // a result that is not the last of its run is always followed by another
  a_run_follow: assert property (@(posedge clk) disable iff (rst)
    out_acc && !m_tdata[8] |=> m_tvalid)
    else $error("run cut short");
`endif

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // scanner modes and separator kinds of the text predictor
  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_TAG,
    MODE_COMMENT,
    MODE_SCRIPT,
    MODE_STYLE
  } scan_mode_t;

  typedef enum logic [1:0] {
    SEP_NONE,
    SEP_SPACE,
    SEP_NEWLINE
  } sep_t;

  localparam int NUM_PATS    = 8;

  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_ITEMS  = 250;   // accepted requests per idling phase
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } html_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       doc_end;
  } text_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  html_readable_text_extractor_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // idling per phase: none, sender only, receiver only, both
  int gap_pct   [4] = '{0, 51, 0, 27};
  int stall_pct [4] = '{0, 0, 51, 27};

  html_req_t  html_queue [$];      // requests still to be driven
  text_res_t  expected_text [$];   // predicted results, oldest first
  logic [7:0] doc_buf [$];         // document under construction
  html_req_t  next_req;
  int         bytes_taken = 0;
  int         mismatches = 0;

  // predictor state
  scan_mode_t scan_mode = MODE_TEXT;
  logic [3:0] open_pos  = '0;
  logic [7:0] open_live = '0;
  logic [3:0] close_pos = '0;
  sep_t       pend_sep  = SEP_NONE;
  logic       text_seen = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int phase_now();
    return (bytes_taken / PHASE_ITEMS) % 4;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    if (b >= hrte_pkg::CH_UPPER_A && b <= hrte_pkg::CH_UPPER_Z) begin
      return b | hrte_pkg::CASE_OFFSET;
    end
    return b;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == hrte_pkg::CH_SPACE || b == hrte_pkg::CH_TAB ||
           b == hrte_pkg::CH_CR || b == hrte_pkg::CH_NL;
  endfunction

  // text after '<' for each opening matcher; wildcards stand for terminator and digit
  function automatic string open_pattern(input int k);
    case (k)
      0:       return "!--";
      1:       return "script#";
      2:       return "style#";
      3:       return "/p>";
      4:       return "/div>";
      5:       return "/li>";
      6:       return "/br>";
      default: return "/h%>";
    endcase
  endfunction

  function automatic logic char_fits(input logic [7:0] p, input logic [7:0] b);
    if (p == hrte_pkg::PAT_TERM) begin
      return b == hrte_pkg::CH_GT || is_blank(b);
    end
    if (p == hrte_pkg::PAT_DIGIT) begin
      return b >= hrte_pkg::CH_1 && b <= hrte_pkg::CH_6;
    end
    return to_lower(b) == p;
  endfunction

  task automatic clear_scan();
    scan_mode = MODE_TEXT;
    open_pos  = '0;
    open_live = '0;
    close_pos = '0;
    pend_sep  = SEP_NONE;
    text_seen = 1'b0;
  endtask

  task automatic begin_tag();
    scan_mode = MODE_TAG;
    open_pos  = 4'd1;
    open_live = 8'hFF;
  endtask

  // one byte inside a tag: advance every live opening matcher
  task automatic tag_advance(input logic [7:0] b);
    int    hit;
    string p;
    hit = -1;
    if (open_live != 0 && open_pos >= 1 && open_pos <= 7) begin
      for (int k = 0; k < NUM_PATS; k++) begin
        if (open_live[k]) begin
          p = open_pattern(k);
          if (open_pos <= p.len() && char_fits(p[open_pos - 1], b)) begin
            if (open_pos == p.len() && hit < 0) begin
              hit = k;
            end
          end else begin
            open_live[k] = 1'b0;
          end
        end
      end
      open_pos = open_pos + 4'd1;
    end else begin
      open_live = '0;
    end
    if (hit >= 0) begin
      open_live = '0;
      open_pos  = '0;
      close_pos = '0;
      case (hit)
        hrte_pkg::PAT_COMMENT: scan_mode = MODE_COMMENT;
        hrte_pkg::PAT_SCRIPT:  scan_mode = MODE_SCRIPT;
        hrte_pkg::PAT_STYLE:   scan_mode = MODE_STYLE;
        default: begin
          // block close makes the pending separator a newline once text has been seen
          if (text_seen && pend_sep != SEP_NEWLINE) begin
            pend_sep = SEP_NEWLINE;
          end
          scan_mode = MODE_TEXT;
        end
      endcase
    end else if (b == hrte_pkg::CH_GT) begin
      scan_mode = MODE_TEXT;
      open_live = '0;
      open_pos  = '0;
    end
  endtask

  // script or style body: look for the closing tag, '<' restarts it
  task automatic body_advance(input logic [7:0] b, input string closer);
    logic [7:0] want;
    if (b == hrte_pkg::CH_LT) begin
      close_pos = 4'd1;
    end else begin
      want = closer[close_pos];
      if (close_pos >= 1 && close_pos < closer.len() && to_lower(b) == want) begin
        close_pos = close_pos + 4'd1;
        if (close_pos == closer.len()) begin
          scan_mode = MODE_TEXT;
          close_pos = '0;
        end
      end else begin
        close_pos = '0;
      end
    end
  endtask

  // work out the text results of one accepted request
  task automatic predict_text(input logic [7:0] b, input logic last);
    logic [7:0] outs [2];
    logic       has_byte [2];
    int         n;
    text_res_t  r;
    n = 0;
    has_byte[0] = 1'b1;
    has_byte[1] = 1'b1;
    case (scan_mode)
      MODE_TAG: begin
        if (b == hrte_pkg::CH_LT) begin
          begin_tag();
        end else begin
          tag_advance(b);
        end
      end
      MODE_COMMENT: begin
        if (b == hrte_pkg::CH_DASH) begin
          close_pos = (close_pos < 2) ? close_pos + 4'd1 : 4'd2;
        end else if (b == hrte_pkg::CH_GT && close_pos == 2) begin
          scan_mode = MODE_TEXT;
          close_pos = '0;
        end else begin
          close_pos = '0;
        end
      end
      MODE_SCRIPT: body_advance(b, "</script>");
      MODE_STYLE:  body_advance(b, "</style>");
      default: begin
        scan_mode = MODE_TEXT;
        if (b == hrte_pkg::CH_LT) begin
          begin_tag();
        end else if (is_blank(b)) begin
          if (text_seen && pend_sep == SEP_NONE) begin
            pend_sep = SEP_SPACE;
          end
        end else begin
          // pending separator goes out right before the text byte
          if (pend_sep != SEP_NONE) begin
            outs[n] = (pend_sep == SEP_SPACE) ? hrte_pkg::CH_SPACE : hrte_pkg::CH_NL;
            n++;
          end
          outs[n] = b;
          n++;
          pend_sep  = SEP_NONE;
          text_seen = 1'b1;
        end
      end
    endcase
    // end of document with no text: a bare end marker
    if (last && n == 0) begin
      outs[0] = '0;
      has_byte[0] = 1'b0;
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      r.out_byte   = outs[k];
      r.byte_valid = has_byte[k];
      r.run_last   = (k == n - 1);
      r.doc_end    = last && (k == n - 1);
      expected_text.insert(expected_text.size(), r);
    end
    if (last) begin
      clear_scan();
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("tb: mismatch at %0t ns: %s", $time, what);
    end
  endtask

  // ---------------------------------------------------------------- document builder

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(3))
      0:       return hrte_pkg::CH_SPACE;
      1:       return hrte_pkg::CH_TAB;
      2:       return hrte_pkg::CH_CR;
      default: return hrte_pkg::CH_NL;
    endcase
  endfunction

  // appends one byte to the document under construction
  task automatic add_byte(input logic [7:0] c);
    doc_buf.insert(doc_buf.size(), c);
  endtask

  // letters come out in random case when mixed is set
  task automatic add_str(input string s, input bit mixed);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mixed && c >= 8'h61 && c <= 8'h7A && $urandom_range(1) == 1) begin
        c = c - hrte_pkg::CASE_OFFSET;
      end
      add_byte(c);
    end
  endtask

  // moves the built document into the request queue, last byte flagged
  task automatic flush_doc();
    html_req_t req;
    if (doc_buf.size() == 0) begin
      add_byte(hrte_pkg::CH_SPACE);
    end
    for (int i = 0; i < doc_buf.size(); i++) begin
      req.data = doc_buf[i];
      req.last = (i == doc_buf.size() - 1);
      html_queue.insert(html_queue.size(), req);
    end
    doc_buf.delete();
  endtask

  task automatic add_block_close();
    add_str("</", 1'b0);
    case ($urandom_range(4))
      0: add_str("p", 1'b1);
      1: add_str("div", 1'b1);
      2: add_str("li", 1'b1);
      3: add_str("br", 1'b1);
      default: begin
        add_str("h", 1'b1);
        add_byte($urandom_range(4) != 0 ? pick("123456") : pick("0789a"));
      end
    endcase
    // now and then a broken name that must not count as a block close
    if ($urandom_range(5) == 0) begin
      add_byte(pick("xa 1"));
    end
    add_byte(hrte_pkg::CH_GT);
  endtask

  task automatic add_plain_tag();
    add_byte(hrte_pkg::CH_LT);
    if ($urandom_range(2) == 0) begin
      add_str("/", 1'b0);
    end
    case ($urandom_range(7))
      0: add_str("a", 1'b1);
      1: add_str("span", 1'b1);
      2: add_str("scrip", 1'b1);
      3: add_str("styles", 1'b1);
      4: add_str("b", 1'b1);
      5: add_str("!-", 1'b0);
      6: add_str("h7", 1'b1);
      default: add_str("pre", 1'b1);
    endcase
    if ($urandom_range(2) == 0) begin
      add_byte(rand_blank());
      add_str("id=x", 1'b1);
    end
    // a '<' inside the tag restarts the opening matchers
    if ($urandom_range(4) == 0) begin
      add_str("</p", 1'b1);
    end
    add_byte(hrte_pkg::CH_GT);
  endtask

  task automatic add_comment();
    add_str("<!--", 1'b0);
    repeat ($urandom_range(8)) add_byte(pick("-->a <"));
    add_str($urandom_range(3) == 0 ? "--->" : "-->", 1'b0);
  endtask

  task automatic add_raw_body(input bit is_script);
    logic [7:0] term;
    string      name;
    name = is_script ? "script" : "style";
    add_byte(hrte_pkg::CH_LT);
    add_str(name, 1'b1);
    case ($urandom_range(4))
      0:       term = hrte_pkg::CH_GT;
      1:       term = hrte_pkg::CH_SPACE;
      2:       term = hrte_pkg::CH_TAB;
      3:       term = hrte_pkg::CH_CR;
      default: term = hrte_pkg::CH_NL;
    endcase
    add_byte(term);
    if (term != hrte_pkg::CH_GT) begin
      add_str("type=t>", 1'b1);
    end
    repeat ($urandom_range(10)) begin
      if ($urandom_range(5) == 0) begin
        add_str(is_script ? "</scr" : "</sty", 1'b1);
      end else begin
        add_byte(pick("ab</>tS -"));
      end
    end
    add_str(is_script ? "</script>" : "</style>", 1'b1);
  endtask

  task automatic add_fragment();
    case ($urandom_range(9))
      0, 1, 9: begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(4) == 0) begin
            add_byte(8'($urandom_range(255)));
          end else begin
            add_byte(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,;&"));
          end
        end
      end
      2:       repeat ($urandom_range(1, 3)) add_byte(rand_blank());
      3:       add_block_close();
      4:       add_plain_tag();
      5:       add_comment();
      6:       add_raw_body(1'b1);
      7:       add_raw_body(1'b0);
      default: repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
    endcase
  endtask

  // ---------------------------------------------------------------- request driver

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_text(s_tdata, s_tlast);
        bytes_taken <= bytes_taken + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (html_queue.size() != 0 && $urandom_range(99) >= gap_pct[phase_now()]) begin
          next_req = html_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_req.data;
          s_tlast  <= next_req.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result monitor

  text_res_t got_exp;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("result %h/%b/%b with nothing expected",
                                    m_tdata, m_tuser, m_tlast));
        end else begin
          got_exp = expected_text.pop_front();
          if (m_tdata[7:0] !== got_exp.out_byte) begin
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      m_tdata[7:0], got_exp.out_byte));
          end
          if (m_tdata[8] !== got_exp.run_last) begin
            report_mismatch($sformatf("run_last %b, expected %b",
                                      m_tdata[8], got_exp.run_last));
          end
          if (m_tdata[15:9] !== 7'd0) begin
            report_mismatch($sformatf("tdata pad bits %h not zero", m_tdata[15:9]));
          end
          if (m_tuser !== got_exp.byte_valid) begin
            report_mismatch($sformatf("byte_valid %b, expected %b",
                                      m_tuser, got_exp.byte_valid));
          end
          if (m_tlast !== got_exp.doc_end) begin
            report_mismatch($sformatf("doc_end %b, expected %b",
                                      m_tlast, got_exp.doc_end));
          end
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct[phase_now()]);
    end
  end

  // ---------------------------------------------------------------- stimulus and end of run

  initial begin
    int target;

    // directed: byte extremes with a space between them
    add_byte(8'h00);
    add_byte(hrte_pkg::CH_SPACE);
    add_byte(8'hFF);
    flush_doc();
    // block close in mixed case gives a newline
    add_str("a</Br>b", 1'b0);
    flush_doc();
    // document of whitespace only ends with a bare marker
    add_byte(hrte_pkg::CH_SPACE);
    flush_doc();
    // comment dropped, then text that ends the document
    add_str("<!-- x -->y", 1'b0);
    flush_doc();
    // document ending inside a tag
    add_str("<i", 1'b0);
    flush_doc();

    // random documents, some cut short inside markup
    target = html_queue.size() + RANDOM_ITEMS;
    while (html_queue.size() < target) begin
      repeat ($urandom_range(1, 10)) add_fragment();
      if ($urandom_range(6) == 0 && doc_buf.size() > 1) begin
        int keep;
        keep = $urandom_range(1, doc_buf.size());
        while (doc_buf.size() > keep) doc_buf.delete(doc_buf.size() - 1);
      end
      flush_doc();
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // all requests taken, then all results back, then a short drain
    while (html_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_text.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_text.size()));
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
